[rtl/rlcfd_pkg.sv]
// Shared types, constants and helper functions for the LED command frame driver.
`timescale 1ns / 1ps

package rlcfd_pkg;

  localparam int LINE_LEN = 12;
  localparam int CNT_W    = $clog2(LINE_LEN + 1);
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
  localparam int IDX_W    = 5;

  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_HASH = 8'h23;
  localparam logic [7:0] CHR_D    = 8'h44;
  localparam logic [7:0] CHR_6    = 8'h36;
  localparam logic [7:0] CHR_8    = 8'h38;
  localparam logic [7:0] LED_HEAD = 8'hE0;
  localparam logic [7:0] FILL_LO  = 8'h00;
  localparam logic [7:0] FILL_HI  = 8'hFF;
  localparam logic [7:0] WHEEL_A  = 8'd85;
  localparam logic [7:0] WHEEL_B  = 8'd170;

  localparam logic [7:0] RAINBOW_WORD [LINE_LEN] = '{
    8'h23, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h52,
    8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
  };

  typedef enum logic [1:0] {
    CH_ECHO   = 2'd0,
    CH_STATUS = 2'd1,
    CH_LED    = 2'd2
  } chan_t;

  typedef enum logic [1:0] {
    ST_COLOR   = 2'd0,
    ST_RAINBOW = 2'd1,
    ST_FORMAT  = 2'd2,
    ST_HEX     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_ECHO   = 2'd0,
    JOB_STATUS = 2'd1,
    JOB_COLOR  = 2'd2,
    JOB_WHEEL  = 2'd3
  } job_t;

  typedef struct packed {
    job_t        job;
    logic [7:0]  echo;
    status_t     status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  lit;
  } desc_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

[rtl/rlcfd_front.sv]
// Front end: accepts items, keeps the line store and classifies finished lines.
`timescale 1ns / 1ps

module rlcfd_front
  import rlcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output logic       push,
  output desc_t      push_desc,
  input  logic       q_full
);

  logic [7:0]       store_r [LINE_LEN];
  logic [7:0]       store_nxt [LINE_LEN];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic             pend_r, pend_nxt;
  logic             kind_r;
  logic [7:0]       byte_r;
  logic             end_r;
  logic             rainbow_r, rainbow_nxt;
  logic [7:0]       wheel_r, wheel_nxt;
  logic             accept, line_end, cr_seen;

  logic             rb_match, hex_ok, fmt_ok;
  logic [7:0]       p, q, q3, r_w, g_w, b_w;
  logic             has_result, fire;
  logic [7:0]       lit_code;

  assign in_ready = !pend_r;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = cnt_r + 1'b1;
  assign cr_seen  = (in_byte == CHR_CR);
  assign line_end = cr_seen || (cnt_inc == CNT_W'(LINE_LEN));

  // Store the byte and, after a carriage return, a zero terminator.
  always_comb begin
    for (int i = 0; i < LINE_LEN; i++) begin
      store_nxt[i] = store_r[i];
      if (accept && !in_kind) begin
        if (cnt_r == CNT_W'(i)) begin
          store_nxt[i] = in_byte;
        end else if (cr_seen && cnt_inc == CNT_W'(i)) begin
          store_nxt[i] = 8'h00;
        end
      end
    end
  end

  // Line check on the stored characters.
  always_comb begin
    rb_match = 1'b1;
    for (int i = 1; i < LINE_LEN; i++) begin
      if (store_r[i] != RAINBOW_WORD[i]) rb_match = 1'b0;
    end
    hex_ok = 1'b1;
    for (int i = 1; i <= 6; i++) begin
      if (!is_hex(store_r[i])) hex_ok = 1'b0;
    end
    fmt_ok = (store_r[7] == CHR_D) && (store_r[8] >= CHR_6) &&
             (store_r[8] <= CHR_8) && (store_r[9] == CHR_CR);
  end

  // Color wheel for the current position.
  always_comb begin
    p = ~wheel_r;
    if (p < WHEEL_A) begin
      q = p;
    end else if (p < WHEEL_B) begin
      q = p - WHEEL_A;
    end else begin
      q = p - WHEEL_B;
    end
    q3 = q + {q[6:0], 1'b0};
    if (p < WHEEL_A) begin
      r_w = FILL_HI - q3; g_w = FILL_LO; b_w = q3;
    end else if (p < WHEEL_B) begin
      r_w = FILL_LO; g_w = q3; b_w = FILL_HI - q3;
    end else begin
      r_w = q3; g_w = FILL_HI - q3; b_w = FILL_LO;
    end
  end

  assign lit_code = store_r[8] - CHR_6;

  // Build the job descriptor and the state changes it carries.
  always_comb begin
    push_desc        = '0;
    push_desc.echo   = byte_r;
    rainbow_nxt      = rainbow_r;
    wheel_nxt        = wheel_r;
    has_result       = 1'b1;
    fire             = pend_r && !q_full;
    if (kind_r) begin
      has_result       = rainbow_r;
      push_desc.job    = JOB_WHEEL;
      push_desc.red    = r_w;
      push_desc.green  = g_w;
      push_desc.blue   = b_w;
      if (fire && rainbow_r) wheel_nxt = wheel_r + 8'd1;
    end else if (!end_r) begin
      push_desc.job    = JOB_ECHO;
    end else begin
      push_desc.job    = JOB_STATUS;
      priority if (store_r[0] != CHR_HASH) begin
        push_desc.status = ST_FORMAT;
      end else if (rb_match) begin
        push_desc.status = ST_RAINBOW;
        if (fire) rainbow_nxt = 1'b1;
      end else if (!hex_ok) begin
        push_desc.status = ST_HEX;
      end else if (!fmt_ok) begin
        push_desc.status = ST_FORMAT;
      end else begin
        push_desc.job    = JOB_COLOR;
        push_desc.status = ST_COLOR;
        push_desc.red    = {hex_val(store_r[1]), hex_val(store_r[2])};
        push_desc.green  = {hex_val(store_r[3]), hex_val(store_r[4])};
        push_desc.blue   = {hex_val(store_r[5]), hex_val(store_r[6])};
        push_desc.lit    = lit_code[1:0];
        if (fire) rainbow_nxt = 1'b0;
      end
    end
    push = fire && has_result;
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      pend_nxt = 1'b1;
      if (!in_kind) cnt_nxt = line_end ? '0 : cnt_inc;
    end else if (fire) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      cnt_r     <= '0;
      rainbow_r <= 1'b0;
      wheel_r   <= '0;
      for (int i = 0; i < LINE_LEN; i++) store_r[i] <= '0;
    end else begin
      pend_r    <= pend_nxt;
      cnt_r     <= cnt_nxt;
      rainbow_r <= rainbow_nxt;
      wheel_r   <= wheel_nxt;
      for (int i = 0; i < LINE_LEN; i++) store_r[i] <= store_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      byte_r <= in_byte;
      end_r  <= line_end;
    end
  end

endmodule

[rtl/rlcfd_fifo.sv]
// Short job queue between the front end and the frame sequencer.
`timescale 1ns / 1ps

module rlcfd_fifo
  import rlcfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_desc;
  end

endmodule

[rtl/rlcfd_back.sv]
// Back end: steps through one job and emits its results into the output register.
`timescale 1ns / 1ps

module rlcfd_back
  import rlcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] brightness,
  input  desc_t      head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_chan,
  output logic [7:0] out_data,
  output logic [1:0] out_status,
  output logic       out_last
);

  desc_t            desc_r;
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ovalid_r, ovalid_nxt;
  chan_t            chan_r, chan_c;
  logic [7:0]       data_r, data_c;
  status_t          status_r, status_c;
  logic             last_r, last_c;
  logic             load, is_color;
  logic [IDX_W-1:0] fpos, zlen, led_end, fend, k;
  logic [7:0]       head_byte;

  assign pop      = !busy_r && !q_empty;
  assign load     = busy_r && (!ovalid_r || out_ready);
  assign is_color = (desc_r.job == JOB_COLOR);
  assign zlen     = is_color ? IDX_W'(8) : IDX_W'(4);
  assign led_end  = zlen + IDX_W'(12);
  assign fend     = {zlen[IDX_W-2:0], 1'b0} + IDX_W'(11);
  assign fpos     = is_color ? idx_r - IDX_W'(2) : idx_r;
  assign k        = fpos - zlen;
  assign head_byte = LED_HEAD | {3'b000, brightness};

  // Result for the current step of the job.
  always_comb begin
    chan_c   = CH_LED;
    data_c   = FILL_LO;
    status_c = ST_COLOR;
    last_c   = 1'b0;
    if (desc_r.job != JOB_WHEEL && idx_r == '0) begin
      chan_c = CH_ECHO;
      data_c = desc_r.echo;
      last_c = (desc_r.job == JOB_ECHO);
    end else if (desc_r.job != JOB_WHEEL && idx_r == IDX_W'(1)) begin
      chan_c   = CH_STATUS;
      status_c = desc_r.status;
      last_c   = (desc_r.job == JOB_STATUS);
    end else begin
      last_c = (fpos == fend);
      if (fpos < zlen) begin
        data_c = FILL_LO;
      end else if (fpos < led_end) begin
        if (desc_r.job == JOB_WHEEL || k[3:2] == desc_r.lit) begin
          unique case (k[1:0])
            2'd0:    data_c = head_byte;
            2'd1:    data_c = desc_r.blue;
            2'd2:    data_c = desc_r.green;
            default: data_c = desc_r.red;
          endcase
        end else begin
          data_c = (k[1:0] == 2'd0) ? LED_HEAD : FILL_LO;
        end
      end else begin
        data_c = FILL_HI;
      end
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r && !out_ready;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (load) begin
      ovalid_nxt = 1'b1;
      idx_nxt    = idx_r + 1'b1;
      if (last_c) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) desc_r <= head;
    if (load) begin
      chan_r   <= chan_c;
      data_r   <= data_c;
      status_r <= status_c;
      last_r   <= last_c;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_chan   = chan_r;
  assign out_data   = data_r;
  assign out_status = status_r;
  assign out_last   = last_r;

endmodule

[rtl/rgb_led_command_frame_driver_core.sv]
// Top level of the LED command frame driver: front end, job queue, sequencer, register.
`timescale 1ns / 1ps
// Flow: an accepted item is registered, then classified and pushed into the queue when it
//   has room; the idle sequencer pops it and its results are registered at the output.
// Throughput: the front end takes no new item until the held one is queued; results
//   leave at one per cycle within a job while out_tready allows, and the next job is popped
//   only after the last result of a job is registered, so a color frame (30 results) sets the pace.
// Reset (rst_n low, synchronous): line store and counters clear, rainbow off, wheel at 0,
//   brightness back to 1, queue and output register empty.

module rgb_led_command_frame_driver_core
  import rlcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data, [9:8] status, [15:10] zero
  output logic [1:0]  out_tuser,  // [1:0] channel
  output logic        out_tlast,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [4:0] bright_r;
  logic       cfg_wr;
  logic       push, q_full, pop, q_empty;
  desc_t      push_desc, head;
  logic [7:0] data_o;
  logic [1:0] status_o;

  // Register file: brightness only, word 0. The low byte-address bits are not decoded.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {27'd0, bright_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 5'd1;
    end else if (cfg_wr && cfg_paddr[2] == 1'b0) begin
      bright_r <= cfg_pwdata[4:0];
    end
  end

  // Front end: store each line byte, check the line at its end, step the wheel on ticks in rainbow mode.
  rlcfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  // Job queue decouples classification from frame emission.
  rlcfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Sequencer: emit echo, status and LED frame bytes, one transfer per cycle within a job while out_tready is high.
  rlcfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .brightness (bright_r),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_chan   (out_tuser),
    .out_data   (data_o),
    .out_status (status_o),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, status_o, data_o};

endmodule
